// ===== hw/rtl/les_pkg.sv =====
// Shared constants and types for the LOOK elevator disk scheduler.
// Holds the table depth, index width, command codes and result status codes.
// Depends on nothing.
`default_nettype none

package les_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ID_W        = 16;
    localparam int TRACK_W     = 16;

    typedef logic [1:0]         t_status;
    typedef logic [ID_W-1:0]    t_id;
    typedef logic [TRACK_W-1:0] t_track;
    typedef logic [IDX_W-1:0]   t_idx;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam t_status ST_ADDED   = 2'd0;
    localparam t_status ST_GRANTED = 2'd1;
    localparam t_status ST_EMPTY   = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/look_elevator_disk_scheduler.sv =====
// Top level of the LOOK elevator disk scheduler: request table and scan sequencer.
// Depends on les_pkg for the table depth, codes and types.
// Add, table-empty and table-full items finish without a scan; select scans the table.
`default_nettype none

// An add item, a select on an empty table, and a rejected add raise o_done
// in the cycle right after the accepting edge, and busy stays low, so such items may
// follow back to back. A select on a non-empty table raises busy while it scans the
// table (one table entry per cycle through a single distance/compare unit), and a
// second pass runs when the sweep reverses; o_done follows the last scan cycle.
// Reset is synchronous and active low: the table empties and the sweep points up.
module look_elevator_disk_scheduler (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            i_command,
    input  wire les_pkg::t_id    i_req_id,
    input  wire les_pkg::t_track i_req_track,
    input  wire les_pkg::t_track i_head_track,
    output logic                 o_done,
    output les_pkg::t_status     o_status,
    output les_pkg::t_id         o_grant_id,
    output les_pkg::t_track      o_grant_track,
    output logic                 o_sweep_down
);
    import les_pkg::*;

    // Sequencer state codes.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Request table. Valid bits reset; id and track are written before use.
    logic [QUEUE_DEPTH-1:0] r_valid;
    t_id                    r_id    [QUEUE_DEPTH];
    t_track                 r_track [QUEUE_DEPTH];
    logic                   r_dir;          // 1 while the sweep moves down

    // Sequencer and the running best candidate of the current pass.
    logic   r_state;
    t_idx   r_idx;
    t_track r_head;
    logic   r_found;
    t_idx   r_bslot;
    t_track r_bdist;
    t_id    r_bid;
    t_track r_btrk;

    // Result registers.
    logic    r_done;
    t_status r_status;
    t_id     r_gid;
    t_track  r_gtrk;
    logic    r_sweep;

    logic   accept;
    logic   table_full;
    logic   table_empty;
    t_idx   free_slot;
    logic   last;

    // Shared distance and compare unit, fed with one table entry per cycle.
    t_id              rd_id;
    t_track           rd_trk;
    logic [TRACK_W:0] diff;
    logic             below;
    t_track           span;
    logic             side_ok;
    logic             qual;
    logic             better;
    logic             take;
    logic             n_found;
    t_idx             n_bslot;
    t_track           n_bdist;
    t_id              n_bid;
    t_track           n_btrk;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign table_full  = &r_valid;
    assign table_empty = ~|r_valid;
    assign last        = (r_idx == IDX_W'(QUEUE_DEPTH - 1));

    // Lowest free slot for an add.
    always_comb begin
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IDX_W'(i);
            end
        end
    end

    always_comb begin
        rd_id   = r_id[r_idx];
        rd_trk  = r_track[r_idx];
        diff    = {1'b0, rd_trk} - {1'b0, r_head};
        below   = diff[TRACK_W];
        span    = below ? TRACK_W'(~diff[TRACK_W-1:0] + TRACK_W'(1)) : diff[TRACK_W-1:0];
        // The head's own track counts as reachable in either direction.
        side_ok = r_dir ? (below || (span == '0)) : !below;
        qual    = r_valid[r_idx] && side_ok;
        // Strict compares keep the lowest slot on a full tie.
        better  = !r_found || (span < r_bdist) || ((span == r_bdist) && (rd_id < r_bid));
        take    = qual && better;
        n_found = r_found || take;
        n_bslot = take ? r_idx  : r_bslot;
        n_bdist = take ? span   : r_bdist;
        n_bid   = take ? rd_id  : r_bid;
        n_btrk  = take ? rd_trk : r_btrk;
    end

    // Control state, valid bits and sweep direction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_dir   <= 1'b0;
            r_done  <= 1'b0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    // Adds and selects on an empty table answer right away.
                    r_done <= accept && ((i_command == CMD_ADD) || table_empty);
                    if (accept) begin
                        if (i_command == CMD_ADD) begin
                            if (!table_full) begin
                                r_valid[free_slot] <= 1'b1;
                            end
                        end else if (!table_empty) begin
                            r_state <= S_SCAN;
                            r_idx   <= '0;
                            r_found <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    r_done  <= last && n_found;
                    r_found <= last ? 1'b0 : n_found;
                    r_idx   <= last ? '0 : r_idx + IDX_W'(1);
                    if (last) begin
                        if (n_found) begin
                            r_valid[n_bslot] <= 1'b0;
                            r_state          <= S_IDLE;
                        end else begin
                            // Nothing ahead: reverse and scan again from slot zero.
                            r_dir <= !r_dir;
                        end
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Table payload, scan candidate and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head <= i_head_track;
            if ((i_command == CMD_ADD) && !table_full) begin
                r_id[free_slot]    <= i_req_id;
                r_track[free_slot] <= i_req_track;
            end
            r_gid   <= '0;
            r_gtrk  <= '0;
            r_sweep <= r_dir;
            if (i_command == CMD_ADD) begin
                r_status <= table_full ? ST_FULL : ST_ADDED;
            end else begin
                r_status <= ST_EMPTY;
            end
        end
        if (r_state == S_SCAN) begin
            r_bslot <= n_bslot;
            r_bdist <= n_bdist;
            r_bid   <= n_bid;
            r_btrk  <= n_btrk;
            if (last && n_found) begin
                r_status <= ST_GRANTED;
                r_gid    <= n_bid;
                r_gtrk   <= n_btrk;
                r_sweep  <= r_dir;
            end
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_grant_id    = r_gid;
    assign o_grant_track = r_gtrk;
    assign o_sweep_down  = r_sweep;

    // An add never waits for the scan unit.
    a_add_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_ADD)) |=> o_done)
        else $error("add item did not complete in one cycle");

    // No result is shown while a scan is in flight.
    a_no_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_done)
        else $error("result strobe during table scan");

    // A grant removes exactly one request from the table.
    a_grant_removes_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_GRANTED)) |->
        ($countones(r_valid) + 1 == $countones($past(r_valid))))
        else $error("grant did not remove exactly one entry");

    // Rejection only happens on a full table, and the table stays full.
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (&r_valid))
        else $error("add rejected while a slot was free");

    // Grant fields are zero unless a request was granted.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_GRANTED)) |->
        ((o_grant_id == '0) && (o_grant_track == '0)))
        else $error("grant fields nonzero without a grant");

endmodule

`default_nettype wire
